FILE: rtl/t1acc_pkg.sv
// ============================================================================
// Top-1 accuracy counter package
// Shared widths, limits and payload types for the accuracy counter blocks.
// ============================================================================
package t1acc_pkg;

  // Row geometry and counter limits.
  localparam int MAX_CLASSES = 256;
  localparam int CLS_W       = 9;
  localparam int IDX_W       = 8;
  localparam int SCORE_W     = 32;
  localparam int CNT_W       = 17;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_BATCH   = 65536;

  // Quotient bits produced by the divider: one integer bit plus the fraction.
  localparam int DIV_STEPS   = FRAC_BITS + 1;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Depth of the tally queue between the front and back parts.
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Input item.
  typedef struct packed {
    logic signed [SCORE_W-1:0] pred_score;
    logic signed [SCORE_W-1:0] target_score;
    logic                      batch_end;
  } t1acc_in_t;

  // Result item.
  typedef struct packed {
    logic [CNT_W-1:0] correct_rows;
    logic [CNT_W-1:0] total_rows;
    logic [CNT_W-1:0] accuracy;
  } t1acc_out_t;

  // Batch totals handed from the front part to the divider.
  typedef struct packed {
    logic [CNT_W-1:0] match_cnt;
    logic [CNT_W-1:0] rows;
  } t1acc_tally_t;

endpackage

FILE: rtl/top1_accuracy_counter.sv
// ============================================================================
// Top-1 accuracy counter
// Counts rows whose predicted argmax matches the target argmax and reports
// the batch totals with the accuracy as an unsigned Q1.16 fraction.
// ============================================================================
//
//   Channel   Handshake          Payload
//   -------   ----------------   ----------------------------------------
//   in        in_valid/in_stall  t1acc_in_t: pred, target scores, batch_end
//   out       out_valid/out_stall t1acc_out_t: correct, total, accuracy
//   cfg       cfg_valid/cfg_ready classes_in_use, 9 bits
//
// Score items are taken one per cycle while the tally queue has room.
// For each batch end the divider loads the totals, makes one quotient bit per
// cycle and then holds the result until the output transfer.
// Synchronous active-low reset; the class count resets to 2.
// in_stall rises only when two batch results are waiting on the divider.
//
module top1_accuracy_counter
  import t1acc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  t1acc_in_t         in_data,
  output logic              in_stall,
  output logic              out_valid,
  output t1acc_out_t        out_data,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLS_W-1:0]  cfg_data
);

  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  t1acc_tally_t q_push_data;
  t1acc_tally_t q_pop_data;

  // The register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  // Argmax tracking and batch counting.
  t1acc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Batch totals waiting for the divider.
  t1acc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Accuracy division and result transfer.
  t1acc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop_data (q_pop_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

FILE: rtl/t1acc_front.sv
// ============================================================================
// Accuracy counter front part
// Tracks the running argmax of both score streams, counts rows and matches,
// and hands the batch totals to the queue when a batch ends.
// ============================================================================
module t1acc_front
  import t1acc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [CLS_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  t1acc_in_t          in_data,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output t1acc_tally_t       q_push_data
);

  localparam logic [CLS_W-1:0] MAX_CLS_V   = CLS_W'(MAX_CLASSES);
  localparam logic [CLS_W-1:0] RESET_CLS_V = CLS_W'(2);
  localparam logic [CNT_W-1:0] MAX_BATCH_V = CNT_W'(MAX_BATCH);

  logic [CLS_W-1:0]          classes_r;
  logic [IDX_W-1:0]          pos_r;
  logic signed [SCORE_W-1:0] pred_best_r;
  logic signed [SCORE_W-1:0] tgt_best_r;
  logic [IDX_W-1:0]          pred_idx_r;
  logic [IDX_W-1:0]          tgt_idx_r;
  logic [CNT_W-1:0]          match_r;
  logic [CNT_W-1:0]          rows_r;

  logic [CLS_W-1:0]          eff_n;
  logic [CLS_W-1:0]          pos_next_cnt;
  logic                      row_end;
  logic                      accept;
  logic                      pred_take;
  logic                      tgt_take;
  logic [IDX_W-1:0]          pred_idx_nxt;
  logic [IDX_W-1:0]          tgt_idx_nxt;
  logic [CNT_W-1:0]          rows_nxt;
  logic [CNT_W-1:0]          match_nxt;

  // A full queue holds off new transfers.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Clamp the class count into its legal range.
  always_comb begin
    priority if (classes_r == '0) begin
      eff_n = CLS_W'(1);
    end else if (classes_r > MAX_CLS_V) begin
      eff_n = MAX_CLS_V;
    end else begin
      eff_n = classes_r;
    end
  end

  // A row ends on the first element at or past the last position.
  assign pos_next_cnt = {1'b0, pos_r} + CLS_W'(1);
  assign row_end      = pos_next_cnt >= eff_n;

  // Running argmax; strict compare keeps the first index on a tie.
  assign pred_take    = (pos_r == '0) || (in_data.pred_score > pred_best_r);
  assign tgt_take     = (pos_r == '0) || (in_data.target_score > tgt_best_r);
  assign pred_idx_nxt = pred_take ? pos_r : pred_idx_r;
  assign tgt_idx_nxt  = tgt_take ? pos_r : tgt_idx_r;

  // Saturating batch counters after this row.
  assign rows_nxt  = (rows_r < MAX_BATCH_V) ? rows_r + CNT_W'(1) : rows_r;
  assign match_nxt = ((pred_idx_nxt == tgt_idx_nxt) && (match_r < MAX_BATCH_V)) ?
                     match_r + CNT_W'(1) : match_r;

  // Batch totals go to the queue on the last element of a batch.
  assign q_push                = accept && row_end && in_data.batch_end;
  assign q_push_data.match_cnt = match_nxt;
  assign q_push_data.rows      = rows_nxt;

  // Configuration register and row state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      classes_r   <= RESET_CLS_V;
      pos_r       <= '0;
      pred_best_r <= '0;
      tgt_best_r  <= '0;
      pred_idx_r  <= '0;
      tgt_idx_r   <= '0;
      match_r     <= '0;
      rows_r      <= '0;
    end else begin
      if (cfg_valid) begin
        classes_r <= cfg_data;
      end
      if (accept) begin
        if (pred_take) begin
          pred_best_r <= in_data.pred_score;
        end
        if (tgt_take) begin
          tgt_best_r <= in_data.target_score;
        end
        pred_idx_r <= pred_idx_nxt;
        tgt_idx_r  <= tgt_idx_nxt;
        if (row_end) begin
          pos_r <= '0;
          if (in_data.batch_end) begin
            match_r <= '0;
            rows_r  <= '0;
          end else begin
            match_r <= match_nxt;
            rows_r  <= rows_nxt;
          end
        end else begin
          pos_r <= pos_next_cnt[IDX_W-1:0];
        end
      end
    end
  end

endmodule

FILE: rtl/t1acc_queue.sv
// ============================================================================
// Accuracy counter tally queue
// Small register queue of batch totals between the front part and the divider.
// ============================================================================
module t1acc_queue
  import t1acc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  t1acc_tally_t  push_data,
  output logic          full,
  input  logic          pop,
  output t1acc_tally_t  pop_data,
  output logic          empty
);

  t1acc_tally_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full     = count_r == QCNT_W'(QDEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/t1acc_back.sv
// ============================================================================
// Accuracy counter back part
// Divides matches by rows one quotient bit per cycle and holds the result
// in an output register until it is taken.
// ============================================================================
module t1acc_back
  import t1acc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  t1acc_tally_t  q_pop_data,
  output logic          q_pop,
  output logic          out_valid,
  output t1acc_out_t    out_data,
  input  logic          out_stall
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   den_r;
  logic [CNT_W-1:0]   quo_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;
  t1acc_out_t         out_data_r;

  logic [CNT_W:0]     trial;
  logic               ge;
  logic [CNT_W:0]     diff;
  logic [CNT_W-1:0]   quo_nxt;

  // One restoring division step; the remainder left after the subtraction always stays below the divisor.
  assign trial   = {1'b0, rem_r};
  assign ge      = trial >= {1'b0, den_r};
  assign diff    = ge ? trial - {1'b0, den_r} : trial;
  assign quo_nxt = {quo_r[CNT_W-2:0], ge};

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer, divider registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            rem_r                   <= q_pop_data.match_cnt;
            den_r                   <= q_pop_data.rows;
            quo_r                   <= '0;
            step_r                  <= '0;
            out_data_r.correct_rows <= q_pop_data.match_cnt;
            out_data_r.total_rows   <= q_pop_data.rows;
            state_r                 <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= {diff[CNT_W-2:0], 1'b0};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            out_data_r.accuracy <= quo_nxt;
            out_valid_r         <= 1'b1;
            state_r             <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/top1_accuracy_counter_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Top-1 accuracy counter testbench
// Streams rows of prediction and target scores into the counter and checks
// every batch result (correct rows, total rows, accuracy) against a
// cycle-free predictor kept alongside the stimulus. Directed rows cover the
// score extremes, ties, early batch ends, out-of-range class counts and a
// class count changed in the middle of a row. Random batches follow, with
// the sender and the receiver idling at several rates.
// ============================================================================
module top1_accuracy_counter_tb;
  import t1acc_pkg::*;

  localparam int                  SETTLE_CYCLES = 64;
  localparam logic [CLS_W-1:0]    RESET_CLASSES = 9'd2;
  localparam logic signed [31:0]  SCORE_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0]  SCORE_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]  SCORE_ONE     = 32'sh0001_0000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  t1acc_in_t  in_data;
  logic       in_stall;
  logic       out_valid;
  t1acc_out_t out_data;
  logic       out_stall;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CLS_W-1:0] cfg_data;

  // Idle rates of the two sides, in percent of cycles.
  int in_idle_pct;
  int out_stall_pct;
  int fail_count;

  // Predictor state: class count, argmax trackers and batch counters.
  logic [CLS_W-1:0]          classes_reg;
  int                        row_pos;
  logic signed [SCORE_W-1:0] pred_best;
  logic signed [SCORE_W-1:0] target_best;
  int                        pred_idx;
  int                        target_idx;
  int                        match_tally;
  int                        row_tally;
  t1acc_out_t                batch_totals_q[$];
  t1acc_out_t                due_totals;

  top1_accuracy_counter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Class count as the block applies it: zero acts as one, large values clip.
  function automatic int active_classes(input logic [CLS_W-1:0] value);
    if (value == 0) return 1;
    if (value > MAX_CLASSES) return MAX_CLASSES;
    return int'(value);
  endfunction

  // Advances the argmax trackers by one score pair and queues the batch
  // totals when a row carrying the batch end completes.
  task automatic tally_score_pair(input t1acc_in_t item);
    int              n;
    longint unsigned quo;
    t1acc_out_t      res;
    n = active_classes(classes_reg);
    if (row_pos == 0 || $signed(item.pred_score) > pred_best) begin
      pred_best = item.pred_score;
      pred_idx  = row_pos;
    end
    if (row_pos == 0 || $signed(item.target_score) > target_best) begin
      target_best = item.target_score;
      target_idx  = row_pos;
    end
    if (row_pos + 1 < n) begin
      row_pos++;
      return;
    end
    row_pos = 0;
    if (row_tally < MAX_BATCH) row_tally++;
    if (pred_idx == target_idx && match_tally < MAX_BATCH) match_tally++;
    if (!item.batch_end) return;
    quo = 0;
    if (row_tally != 0) quo = (longint'(match_tally) << FRAC_BITS) / row_tally;
    res.correct_rows = match_tally[CNT_W-1:0];
    res.total_rows   = row_tally[CNT_W-1:0];
    res.accuracy     = quo[CNT_W-1:0];
    batch_totals_q.push_back(res);
    match_tally = 0;
    row_tally   = 0;
  endtask

  // Sends one score pair, idling first at the current rate.
  task automatic send_score_pair(input t1acc_in_t item);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tally_score_pair(item);
  endtask

  task automatic send_fields(input logic signed [SCORE_W-1:0] pred,
                             input logic signed [SCORE_W-1:0] target,
                             input logic                      last);
    t1acc_in_t item;
    item.pred_score   = pred;
    item.target_score = target;
    item.batch_end    = last;
    send_score_pair(item);
  endtask

  // Drops the input valid, waits for all batch results and lets the divider
  // finish any work that produces no result.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (batch_totals_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_classes(input logic [CLS_W-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    classes_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_field(input string field, input logic [CNT_W-1:0] want,
                            input logic [CNT_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("Mismatch in %s: expected %0d, actual %0d", field, want, got);
  endtask

  // Result check: every output transfer is compared with the oldest batch.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (batch_totals_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result: correct %0d, total %0d, accuracy %0d",
                   out_data.correct_rows, out_data.total_rows, out_data.accuracy);
      end else begin
        due_totals = batch_totals_q.pop_front();
        if (out_data.correct_rows !== due_totals.correct_rows)
          flag_field("correct_rows", due_totals.correct_rows, out_data.correct_rows);
        if (out_data.total_rows !== due_totals.total_rows)
          flag_field("total_rows", due_totals.total_rows, out_data.total_rows);
        if (out_data.accuracy !== due_totals.accuracy)
          flag_field("accuracy", due_totals.accuracy, out_data.accuracy);
      end
    end
  end

  // Receiver stalls at the current rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // The class count after reset is two.
  task automatic test_reset_class_count();
    send_fields(32'sd1, 32'sd0, 1'b0);
    send_fields(32'sd5, SCORE_ONE, 1'b1);
  endtask

  // Score extremes, ties resolved to the first index, batch end flags on
  // elements that do not end a row, and a truncated one-third accuracy.
  task automatic test_extremes_and_ties();
    write_classes(9'd1);
    send_fields(SCORE_MIN, SCORE_MAX, 1'b0);
    send_fields(SCORE_MAX, SCORE_MIN, 1'b0);
    send_fields(32'sd0, -32'sd1, 1'b1);
    write_classes(9'd3);
    send_fields(32'sd7, 32'sd0, 1'b1);
    send_fields(32'sd7, 32'sd0, 1'b0);
    send_fields(32'sd7, 32'sd9, 1'b0);
    send_fields(-32'sd1, SCORE_MIN, 1'b0);
    send_fields(SCORE_MIN, SCORE_MIN, 1'b1);
    send_fields(SCORE_MAX, SCORE_MAX, 1'b0);
    send_fields(SCORE_MAX, 32'sd0, 1'b0);
    send_fields(32'sd0, SCORE_MAX, 1'b0);
    send_fields(32'sd0, 32'sd0, 1'b1);
  endtask

  // A class count of zero behaves as one.
  task automatic test_zero_class_count();
    write_classes(9'd0);
    send_fields(SCORE_ONE, SCORE_ONE, 1'b0);
    send_fields(-SCORE_ONE, 32'sd0, 1'b1);
  endtask

  // Lowering the class count inside a row ends that row on the next element.
  task automatic test_midrow_change();
    write_classes(9'd4);
    send_fields(32'sd1, 32'sd1, 1'b0);
    send_fields(32'sd2, 32'sd2, 1'b0);
    send_fields(32'sd3, 32'sd0, 1'b0);
    write_classes(9'd2);
    send_fields(32'sd9, 32'sd9, 1'b1);
  endtask

  function automatic logic [SCORE_W-1:0] pick_edge_score();
    unique case ($urandom_range(0, 3))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Random batches of well-formed rows with stray batch end flags, over
  // several class counts and idle rates. Rows cut short by a phase change
  // exercise the class count changing inside a row.
  task automatic test_random_traffic();
    int               idle_plan[4];
    int               stall_plan[4];
    logic [CLS_W-1:0] cls_plan[16];
    int               n;
    int               budget;
    int               sent;
    int               rows;
    int               style;
    int               peak_p;
    int               peak_t;
    logic [SCORE_W-1:0] hi;
    logic [SCORE_W-1:0] lo;
    t1acc_in_t        item;
    idle_plan  = '{0, 76, 0, 20};
    stall_plan = '{0, 0, 76, 20};
    cls_plan   = '{9'd2, 9'd1, 9'd7, 9'd256, 9'd3, 9'd0, 9'd5, 9'd511,
                   9'd4, 9'd6, 9'd1, 9'd257, 9'd8, 9'd3, 9'd2, 9'd16};
    for (int ph = 0; ph < 16; ph++) begin
      write_classes(cls_plan[ph]);
      in_idle_pct   = idle_plan[ph / 4];
      out_stall_pct = stall_plan[ph / 4];
      n = active_classes(cls_plan[ph]);
      if (cls_plan[ph] == MAX_CLASSES) budget = n + 4;
      else if (n >= 64) budget = 24;
      else budget = 40;
      sent = 0;
      while (sent < budget) begin
        rows = (n >= 64) ? 1 : $urandom_range(1, 6);
        for (int r = 0; r < rows && sent < budget; r++) begin
          style  = $urandom_range(0, 3);
          peak_p = $urandom_range(0, n - 1);
          peak_t = $urandom_range(0, 1) ? peak_p : $urandom_range(0, n - 1);
          hi     = $urandom();
          lo     = $urandom();
          for (int c = 0; c < n && sent < budget; c++) begin
            unique case (style)
              0: begin
                // One-hot target with a clear prediction peak.
                item.target_score = (c == peak_t) ? SCORE_ONE : '0;
                item.pred_score   = (c == peak_p) ? SCORE_ONE + $urandom_range(0, 65535)
                                                  : $urandom_range(0, 65535) - 32768;
              end
              1: begin
                item.pred_score   = $urandom();
                item.target_score = $urandom();
              end
              2: begin
                // Plateaus from the peak onward: the first equal score wins.
                item.pred_score   = (c >= peak_p) ? hi : lo;
                item.target_score = (c >= peak_t) ? hi : lo;
              end
              default: begin
                item.pred_score   = pick_edge_score();
                item.target_score = pick_edge_score();
              end
            endcase
            item.batch_end = (c == n - 1) ? (r == rows - 1) : ($urandom_range(0, 99) < 15);
            send_score_pair(item);
            sent++;
          end
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    fail_count    = 0;
    classes_reg   = RESET_CLASSES;
    row_pos       = 0;
    pred_best     = '0;
    target_best   = '0;
    pred_idx      = 0;
    target_idx    = 0;
    match_tally   = 0;
    row_tally     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_class_count();
    test_extremes_and_ties();
    test_zero_class_count();
    test_midrow_change();
    test_random_traffic();
    settle_block();

    if (fail_count == 0 && batch_totals_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
